// ===== hdl/best_fit_block_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit block allocator.
// Shared by every file that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Checked property, masked while reset is high.
`define BFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds while reset is high.
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/bfa_pkg.sv =====
// ---------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the best-fit block allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   // Widest word address that the arena parameter range needs.
   localparam int ADDR_MAX = 21;

   localparam logic [63:0] TAG_FREE     = 64'h0837bc96fd3c445e;
   localparam logic [63:0] TAG_OCCUPIED = 64'h07bc96f47d445e3c;
   localparam logic [63:0] TAG_MARKER   = 64'h0846204575037127;

   // Word slots within a chunk header.
   localparam logic [1:0] FLD_TAG  = 2'd0;
   localparam logic [1:0] FLD_SIZE = 2'd1;
   localparam logic [1:0] FLD_PREV = 2'd2;
   localparam logic [1:0] FLD_NEXT = 2'd3;

   localparam int CHUNK_OVERHEAD = 40;
   localparam int FIRST_CHUNK    = 16;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE,
      ST_A_TAG, ST_A_SZ, ST_A_NX, ST_A_ADV, ST_A_FIN,
      ST_A_S0, ST_A_S1, ST_A_S2, ST_A_S3, ST_A_S4, ST_A_S5, ST_A_S6, ST_A_S7,
      ST_F_WALK, ST_F_ADV, ST_F_TAGCHK, ST_F_SZ, ST_F_NB, ST_F_NBTAG, ST_F_NN,
      ST_F_NBSZ, ST_F_NNPREV, ST_F_PV0, ST_F_PV, ST_F_PVTAG, ST_F_PVSZ,
      ST_F_PVNX, ST_DONE
   } state_type;

   // One write port and one read port of the arena memory.
   typedef struct packed {
      logic                we;
      logic [ADDR_MAX-1:0] waddr;
      logic [63:0]         wdata;
      logic [ADDR_MAX-1:0] raddr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== hdl/bfa_arena_ram.sv =====
// ---------------------------------------------------------------------------
// bfa_arena_ram
// Arena word memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_arena_ram #(
   parameter int WORDS = 8192,
   parameter int AW    = 13
) (
   input  wire                       clock,
   input  wire bfa_pkg::mem_req_type mem_req,
   output logic [63:0]               rdata
);

   logic [63:0] mem [WORDS];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr[AW-1:0]];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/bfa_ctrl.sv =====
// ---------------------------------------------------------------------------
// bfa_ctrl
// Sequencer that walks and edits the chunk chain held in the arena memory.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl #(
   parameter int ARENA_BYTES = 65536
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_func,
   input  wire  [15:0]          req_bytes,
   input  wire  [15:0]          block_offset,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           status,
   output logic [15:0]          result_offset,
   output logic [16:0]          used_bytes,
   output logic [16:0]          free_bytes,
   output logic [11:0]          alloc_count,
   output bfa_pkg::mem_req_type mem_req,
   input  wire  [63:0]          mem_rdata
);

   localparam int SPAN  = (ARENA_BYTES / 8) * 8;
   localparam int WORDS = SPAN / 8;
   localparam int AW    = $clog2(WORDS);
   localparam int OFF_W = AW + 3;
   localparam int CW    = (OFF_W > 17) ? OFF_W : 17;
   localparam int XW    = (OFF_W > 16) ? OFF_W : 16;
   localparam int INIT_SIZE = SPAN - 56;

   localparam logic [OFF_W-1:0] FIRST = OFF_W'(bfa_pkg::FIRST_CHUNK);
   localparam logic [CW-1:0]    OVH   = CW'(bfa_pkg::CHUNK_OVERHEAD);
   localparam logic [16:0]      OVH17 = 17'(bfa_pkg::CHUNK_OVERHEAD);

   function automatic logic [bfa_pkg::ADDR_MAX-1:0] widx(input logic [OFF_W-1:0] off,
                                                         input logic [1:0] fld);
      logic [AW-1:0] a;
      a = off[OFF_W-1:3] + AW'(fld);
      return bfa_pkg::ADDR_MAX'(a);
   endfunction

   bfa_pkg::state_type state_ff, state_in;
   logic [OFF_W-1:0] cur_ff, cur_in, found_ff, found_in, nb_ff, nb_in;
   logic [OFF_W-1:0] nn_ff, nn_in, nxt_ff, nxt_in, pb_ff, pb_in;
   logic [CW-1:0]    fsize_ff, fsize_in, req_ff, req_in, sz_ff, sz_in;
   logic [15:0]      tgt_ff, tgt_in;
   logic             tagok_ff, tagok_in;
   logic [1:0]       icnt_ff, icnt_in;
   logic [16:0]      used_ff, used_in, free_ff, free_in;
   logic [11:0]      cnt_ff, cnt_in;
   logic [1:0]       st_ff, st_in;
   logic [15:0]      roff_ff, roff_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rs_status_ff, rs_status_in;
   logic [15:0]      rs_off_ff, rs_off_in;
   logic [16:0]      rs_used_ff, rs_used_in, rs_free_ff, rs_free_in;
   logic [11:0]      rs_cnt_ff, rs_cnt_in;

   logic [OFF_W-1:0] q_off;
   logic [CW-1:0]    q_sz;
   logic             rsp_free;
   logic             split;
   logic [16:0]      req_round;

   assign q_off     = mem_rdata[OFF_W-1:0];
   assign q_sz      = CW'(q_off);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign split     = {1'b0, fsize_ff} > ({1'b0, req_ff} + {1'b0, OVH});
   assign req_round = (17'(req_bytes) + 17'd7) & ~17'd7;
   assign req_ready = (state_ff == bfa_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfa_pkg::ST_INIT:   if (icnt_ff == 2'd3) state_in = bfa_pkg::ST_IDLE;
         bfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == bfa_pkg::FUNC_FREE) ? bfa_pkg::ST_F_WALK
                                                           : bfa_pkg::ST_A_TAG;
            end
         end
         bfa_pkg::ST_A_TAG:  state_in = bfa_pkg::ST_A_SZ;
         bfa_pkg::ST_A_SZ:   state_in = bfa_pkg::ST_A_NX;
         bfa_pkg::ST_A_NX:   state_in = bfa_pkg::ST_A_ADV;
         bfa_pkg::ST_A_ADV:  state_in = (q_off == '0) ? bfa_pkg::ST_A_FIN : bfa_pkg::ST_A_SZ;
         bfa_pkg::ST_A_FIN: begin
            if (found_ff == '0 || !split) state_in = bfa_pkg::ST_DONE;
            else                          state_in = bfa_pkg::ST_A_S0;
         end
         bfa_pkg::ST_A_S0:   state_in = bfa_pkg::ST_A_S1;
         bfa_pkg::ST_A_S1:   state_in = bfa_pkg::ST_A_S2;
         bfa_pkg::ST_A_S2:   state_in = bfa_pkg::ST_A_S3;
         bfa_pkg::ST_A_S3:   state_in = bfa_pkg::ST_A_S4;
         bfa_pkg::ST_A_S4:   state_in = bfa_pkg::ST_A_S5;
         bfa_pkg::ST_A_S5:   state_in = bfa_pkg::ST_A_S6;
         bfa_pkg::ST_A_S6:   state_in = bfa_pkg::ST_A_S7;
         bfa_pkg::ST_A_S7:   state_in = bfa_pkg::ST_DONE;
         bfa_pkg::ST_F_WALK: begin
            state_in = (XW'(cur_ff) == XW'(tgt_ff)) ? bfa_pkg::ST_F_TAGCHK
                                                    : bfa_pkg::ST_F_ADV;
         end
         bfa_pkg::ST_F_ADV:  state_in = (q_off == '0) ? bfa_pkg::ST_DONE : bfa_pkg::ST_F_WALK;
         bfa_pkg::ST_F_TAGCHK: begin
            state_in = (mem_rdata == bfa_pkg::TAG_OCCUPIED) ? bfa_pkg::ST_F_SZ
                                                            : bfa_pkg::ST_DONE;
         end
         bfa_pkg::ST_F_SZ:   state_in = bfa_pkg::ST_F_NB;
         bfa_pkg::ST_F_NB:   state_in = (q_off == '0) ? bfa_pkg::ST_F_PV0 : bfa_pkg::ST_F_NBTAG;
         bfa_pkg::ST_F_NBTAG: begin
            state_in = (mem_rdata == bfa_pkg::TAG_FREE) ? bfa_pkg::ST_F_NN
                                                        : bfa_pkg::ST_F_PV0;
         end
         bfa_pkg::ST_F_NN:   state_in = bfa_pkg::ST_F_NBSZ;
         bfa_pkg::ST_F_NBSZ: begin
            state_in = (nn_ff != '0) ? bfa_pkg::ST_F_NNPREV : bfa_pkg::ST_F_PV0;
         end
         bfa_pkg::ST_F_NNPREV: state_in = bfa_pkg::ST_F_PV0;
         bfa_pkg::ST_F_PV0:  state_in = bfa_pkg::ST_F_PV;
         bfa_pkg::ST_F_PV:   state_in = (q_off == '0) ? bfa_pkg::ST_DONE : bfa_pkg::ST_F_PVTAG;
         bfa_pkg::ST_F_PVTAG: begin
            state_in = (mem_rdata == bfa_pkg::TAG_FREE) ? bfa_pkg::ST_F_PVSZ
                                                        : bfa_pkg::ST_DONE;
         end
         bfa_pkg::ST_F_PVSZ: state_in = bfa_pkg::ST_F_PVNX;
         bfa_pkg::ST_F_PVNX: state_in = bfa_pkg::ST_DONE;
         bfa_pkg::ST_DONE:   if (rsp_free) state_in = bfa_pkg::ST_IDLE;
         default:            state_in = bfa_pkg::ST_INIT;
      endcase
   end

   // Memory accesses and datapath updates.
   always_comb begin
      mem_req      = '0;
      cur_in       = cur_ff;
      found_in     = found_ff;
      nb_in        = nb_ff;
      nn_in        = nn_ff;
      nxt_in       = nxt_ff;
      pb_in        = pb_ff;
      fsize_in     = fsize_ff;
      req_in       = req_ff;
      sz_in        = sz_ff;
      tgt_in       = tgt_ff;
      tagok_in     = tagok_ff;
      icnt_in      = icnt_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      roff_in      = roff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rs_status_in = rs_status_ff;
      rs_off_in    = rs_off_ff;
      rs_used_in   = rs_used_ff;
      rs_free_in   = rs_free_ff;
      rs_cnt_in    = rs_cnt_ff;
      unique case (state_ff)
         bfa_pkg::ST_INIT: begin
            // Lay down the header of the single free chunk.
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(FIRST, icnt_ff);
            case (icnt_ff)
               bfa_pkg::FLD_TAG:  mem_req.wdata = bfa_pkg::TAG_FREE;
               bfa_pkg::FLD_SIZE: mem_req.wdata = 64'(INIT_SIZE);
               default:           mem_req.wdata = '0;
            endcase
            icnt_in = icnt_ff + 2'd1;
         end
         bfa_pkg::ST_IDLE: begin
            cur_in   = FIRST;
            found_in = '0;
            fsize_in = '0;
            req_in   = CW'(req_round);
            tgt_in   = block_offset;
            st_in    = bfa_pkg::STATUS_OK;
            roff_in  = '0;
         end
         bfa_pkg::ST_A_TAG: mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_TAG);
         bfa_pkg::ST_A_SZ: begin
            tagok_in      = (mem_rdata == bfa_pkg::TAG_FREE);
            mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_SIZE);
         end
         bfa_pkg::ST_A_NX: begin
            if (tagok_ff && q_sz >= req_ff && (found_ff == '0 || fsize_ff > q_sz)) begin
               found_in = cur_ff;
               fsize_in = q_sz;
            end
            mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_NEXT);
         end
         bfa_pkg::ST_A_ADV: begin
            cur_in        = q_off;
            mem_req.raddr = widx(q_off, bfa_pkg::FLD_TAG);
         end
         bfa_pkg::ST_A_FIN: begin
            nb_in         = OFF_W'(CW'(found_ff) + OVH + req_ff);
            mem_req.raddr = widx(found_ff, bfa_pkg::FLD_NEXT);
            if (found_ff == '0) begin
               st_in = bfa_pkg::STATUS_NO_SPACE;
            end else if (!split) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = widx(found_ff, bfa_pkg::FLD_TAG);
               mem_req.wdata = bfa_pkg::TAG_OCCUPIED;
               free_in       = free_ff - 17'(fsize_ff);
               used_in       = used_ff + 17'(fsize_ff);
               cnt_in        = cnt_ff + 12'd1;
               roff_in       = 16'(found_ff);
            end
         end
         bfa_pkg::ST_A_S0: begin
            nxt_in        = q_off;
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(nb_ff, bfa_pkg::FLD_TAG);
            mem_req.wdata = bfa_pkg::TAG_FREE;
         end
         bfa_pkg::ST_A_S1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(nb_ff, bfa_pkg::FLD_SIZE);
            mem_req.wdata = 64'(fsize_ff - OVH - req_ff);
         end
         bfa_pkg::ST_A_S2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(nb_ff, bfa_pkg::FLD_NEXT);
            mem_req.wdata = 64'(nxt_ff);
         end
         bfa_pkg::ST_A_S3: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(nb_ff, bfa_pkg::FLD_PREV);
            mem_req.wdata = 64'(found_ff);
         end
         bfa_pkg::ST_A_S4: begin
            mem_req.we    = (nxt_ff != '0);
            mem_req.waddr = widx(nxt_ff, bfa_pkg::FLD_PREV);
            mem_req.wdata = 64'(nb_ff);
         end
         bfa_pkg::ST_A_S5: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(found_ff, bfa_pkg::FLD_NEXT);
            mem_req.wdata = 64'(nb_ff);
         end
         bfa_pkg::ST_A_S6: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(found_ff, bfa_pkg::FLD_SIZE);
            mem_req.wdata = 64'(req_ff);
         end
         bfa_pkg::ST_A_S7: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(found_ff, bfa_pkg::FLD_TAG);
            mem_req.wdata = bfa_pkg::TAG_OCCUPIED;
            free_in       = free_ff - 17'(req_ff) - OVH17;
            used_in       = used_ff + 17'(req_ff);
            cnt_in        = cnt_ff + 12'd1;
            roff_in       = 16'(found_ff);
         end
         bfa_pkg::ST_F_WALK: begin
            if (XW'(cur_ff) == XW'(tgt_ff)) mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_TAG);
            else                            mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_NEXT);
         end
         bfa_pkg::ST_F_ADV: begin
            cur_in = q_off;
            if (q_off == '0) st_in = bfa_pkg::STATUS_BAD_FREE;
         end
         bfa_pkg::ST_F_TAGCHK: begin
            mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_SIZE);
            if (mem_rdata != bfa_pkg::TAG_OCCUPIED) st_in = bfa_pkg::STATUS_BAD_FREE;
         end
         bfa_pkg::ST_F_SZ: begin
            sz_in         = q_sz;
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(cur_ff, bfa_pkg::FLD_TAG);
            mem_req.wdata = bfa_pkg::TAG_FREE;
            used_in       = used_ff - 17'(q_sz);
            free_in       = free_ff + 17'(q_sz);
            cnt_in        = cnt_ff - 12'd1;
            mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_NEXT);
         end
         bfa_pkg::ST_F_NB: begin
            nb_in         = q_off;
            nxt_in        = q_off;
            mem_req.raddr = widx(q_off, bfa_pkg::FLD_TAG);
         end
         bfa_pkg::ST_F_NBTAG: mem_req.raddr = widx(nb_ff, bfa_pkg::FLD_NEXT);
         bfa_pkg::ST_F_NN: begin
            nn_in         = q_off;
            nxt_in        = q_off;
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(cur_ff, bfa_pkg::FLD_NEXT);
            mem_req.wdata = 64'(q_off);
            mem_req.raddr = widx(nb_ff, bfa_pkg::FLD_SIZE);
         end
         bfa_pkg::ST_F_NBSZ: begin
            sz_in         = sz_ff + q_sz + OVH;
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(cur_ff, bfa_pkg::FLD_SIZE);
            mem_req.wdata = 64'(sz_ff + q_sz + OVH);
            free_in       = free_ff + OVH17;
         end
         bfa_pkg::ST_F_NNPREV: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(nn_ff, bfa_pkg::FLD_PREV);
            mem_req.wdata = 64'(cur_ff);
         end
         bfa_pkg::ST_F_PV0: mem_req.raddr = widx(cur_ff, bfa_pkg::FLD_PREV);
         bfa_pkg::ST_F_PV: begin
            pb_in         = q_off;
            mem_req.raddr = widx(q_off, bfa_pkg::FLD_TAG);
         end
         bfa_pkg::ST_F_PVTAG: begin
            mem_req.raddr = widx(pb_ff, bfa_pkg::FLD_SIZE);
            if (mem_rdata == bfa_pkg::TAG_FREE && nxt_ff != '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = widx(nxt_ff, bfa_pkg::FLD_PREV);
               mem_req.wdata = 64'(pb_ff);
            end
         end
         bfa_pkg::ST_F_PVSZ: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(pb_ff, bfa_pkg::FLD_SIZE);
            mem_req.wdata = 64'(q_sz + sz_ff + OVH);
            free_in       = free_ff + OVH17;
         end
         bfa_pkg::ST_F_PVNX: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = widx(pb_ff, bfa_pkg::FLD_NEXT);
            mem_req.wdata = 64'(nxt_ff);
         end
         bfa_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rs_status_in = st_ff;
               rs_off_in    = roff_ff;
               rs_used_in   = used_ff;
               rs_free_in   = free_ff;
               rs_cnt_in    = cnt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::ST_INIT;
         icnt_ff      <= '0;
         used_ff      <= '0;
         free_ff      <= 17'(INIT_SIZE);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         icnt_ff      <= icnt_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      found_ff     <= found_in;
      nb_ff        <= nb_in;
      nn_ff        <= nn_in;
      nxt_ff       <= nxt_in;
      pb_ff        <= pb_in;
      fsize_ff     <= fsize_in;
      req_ff       <= req_in;
      sz_ff        <= sz_in;
      tgt_ff       <= tgt_in;
      tagok_ff     <= tagok_in;
      st_ff        <= st_in;
      roff_ff      <= roff_in;
      rs_status_ff <= rs_status_in;
      rs_off_ff    <= rs_off_in;
      rs_used_ff   <= rs_used_in;
      rs_free_ff   <= rs_free_in;
      rs_cnt_ff    <= rs_cnt_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign status        = rs_status_ff;
   assign result_offset = rs_off_ff;
   assign used_bytes    = rs_used_ff;
   assign free_bytes    = rs_free_ff;
   assign alloc_count   = rs_cnt_ff;

endmodule

`default_nettype wire

// ===== hdl/best_fit_block_allocator.sv =====
// An allocate reads the tag, size and next word of every chunk in the chain, then does
// setup, split and bookkeeping; a free walks the chain up to the target, then checks the
// target and merges it with free neighbours. Both walks are set by the single read port
// of the arena memory. One request is worked at a time, and the next is accepted in the
// idle state, which is entered as the result goes into the output register.
// Reset is synchronous; after it the four words of the initial free chunk header are written.
// ---------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit chunk allocator with coalescing over a word-organized arena memory.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator #(
   parameter int ARENA_BYTES = 65536
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // req_tdata: [15:0] req_bytes, [31:16] block_offset
   input  wire  [31:0] req_tdata,
   // req_tuser: [0] func
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // rsp_tdata: [15:0] result_offset, [32:16] used_bytes, [49:33] free_bytes,
   //            [61:50] alloc_count, [63:62] zero
   output logic [63:0] rsp_tdata,
   // rsp_tuser: [1:0] status
   output logic [1:0]  rsp_tuser
);

   localparam int WORDS = (ARENA_BYTES / 8);
   localparam int AW    = $clog2(WORDS);

   bfa_pkg::mem_req_type mem_req;
   logic [63:0]          mem_rdata;
   logic [15:0]          result_offset;
   logic [16:0]          used_bytes;
   logic [16:0]          free_bytes;
   logic [11:0]          alloc_count;

   // The arena holds every chunk header word. End markers are never read back by
   // the chain walk, so the memory only ever receives header writes.
   bfa_arena_ram #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // The sequencer walks the chain for the best fit or the chunk to free, then
   // rewrites the affected headers one word at a time.
   bfa_ctrl #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_func      (req_tuser[0]),
      .req_bytes     (req_tdata[15:0]),
      .block_offset  (req_tdata[31:16]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .status        (rsp_tuser),
      .result_offset (result_offset),
      .used_bytes    (used_bytes),
      .free_bytes    (free_bytes),
      .alloc_count   (alloc_count),
      .mem_req       (mem_req),
      .mem_rdata     (mem_rdata)
   );

   assign rsp_tdata = {2'b00, alloc_count, free_bytes, used_bytes, result_offset};

endmodule

`default_nettype wire

// ===== hdl/bfa_checker.sv =====
// ---------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the best-fit block allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "best_fit_block_allocator_defines.svh"

module bfa_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);

   logic        rsp_stall;
   logic        rsp_ok;
   logic [65:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_ok    = (rsp_tuser == bfa_pkg::STATUS_OK);
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // A result waiting for the sink holds steady.
   `BFA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "rsp changed while stalled")

   // A failed request never reports an offset.
   `BFA_ASSERT(a_fail_zero, rsp_tvalid && !rsp_ok |-> rsp_tdata[15:0] == 16'd0, "offset on failure")

   // Chunk offsets granted by an allocate are 8-byte aligned.
   `BFA_ASSERT(a_align, rsp_tvalid && rsp_ok |-> rsp_tdata[2:0] == 3'd0, "unaligned offset")

   // The header initialization after reset holds requests off the port.
   `BFA_ASSERT_ALWAYS(a_init_busy, reset |=> !req_tready, "request taken during initialization")

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/tb_best_fit_block_allocator.sv =====
// ---------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Self-checking bench for the best-fit block allocator. A predictor that
// mirrors the arena word by word computes every response. Requests and
// responses move under random idle cycles, a long response hold-off and a
// full drain pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_best_fit_block_allocator;

   localparam int ARENA       = 65536;
   localparam int ARENA_WORDS = ARENA / 8;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 200;

   // Fields of one expected response.
   typedef struct {
      bfa_pkg::status_type status;
      logic [15:0]         offset;
      logic [16:0]         used;
      logic [16:0]         free;
      logic [11:0]         count;
   } alloc_response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   best_fit_block_allocator #(.ARENA_BYTES(ARENA)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Predictor state: a copy of the arena words and the running totals.
   bit [63:0] arena_copy [ARENA_WORDS];
   bit [31:0] used_sum;
   bit [31:0] free_sum;
   bit [31:0] live_count;

   alloc_response_type pending_responses [$];
   int unsigned        live_offsets [$];

   int  error_count = 0;
   int  alloc_ok_count = 0;
   int  no_space_count = 0;
   int  free_ok_count = 0;
   int  bad_free_count = 0;
   bit  idle_enable = 1'b1;
   int  hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Predictor
   // -----------------------------------------------------------------------
   function automatic bit [63:0] arena_read(bit [63:0] off, int field);
      bit [63:0] idx;
      idx = off / 8 + field;
      return (idx < ARENA_WORDS) ? arena_copy[idx] : 64'd0;
   endfunction

   function automatic void arena_write(bit [63:0] off, int field, bit [63:0] value);
      bit [63:0] idx;
      idx = off / 8 + field;
      if (idx < ARENA_WORDS) arena_copy[idx] = value;
   endfunction

   // The end marker sits right after the data area of a chunk.
   function automatic void place_marker(bit [63:0] off);
      arena_write(off + 32 + arena_read(off, bfa_pkg::FLD_SIZE), 0, bfa_pkg::TAG_MARKER);
   endfunction

   function automatic void arena_init();
      bit [63:0] first_size;
      first_size = ARENA - 56;
      foreach (arena_copy[i]) arena_copy[i] = 64'd0;
      arena_copy[0] = bfa_pkg::FIRST_CHUNK;
      arena_copy[1] = ARENA;
      arena_write(bfa_pkg::FIRST_CHUNK, bfa_pkg::FLD_TAG, bfa_pkg::TAG_FREE);
      arena_write(bfa_pkg::FIRST_CHUNK, bfa_pkg::FLD_SIZE, first_size);
      arena_write(bfa_pkg::FIRST_CHUNK, bfa_pkg::FLD_PREV, 64'd0);
      arena_write(bfa_pkg::FIRST_CHUNK, bfa_pkg::FLD_NEXT, 64'd0);
      place_marker(bfa_pkg::FIRST_CHUNK);
      used_sum   = 0;
      free_sum   = first_size;
      live_count = 0;
   endfunction

   // Best fit: smallest free chunk that holds the rounded request, earliest on ties.
   function automatic bfa_pkg::status_type predict_alloc(bit [15:0] bytes,
                                                         output bit [63:0] found);
      bit [63:0] need, cur, best_size, chunk_size, split_at, next_chunk;
      need = (64'(bytes) + 7) & ~64'd7;
      cur = bfa_pkg::FIRST_CHUNK;
      found = 0;
      best_size = 0;
      for (int n = 0; n < ARENA_WORDS && cur != 0; n++) begin
         chunk_size = arena_read(cur, bfa_pkg::FLD_SIZE);
         if (arena_read(cur, bfa_pkg::FLD_TAG) == bfa_pkg::TAG_FREE && chunk_size >= need &&
             (found == 0 || best_size > chunk_size)) begin
            found = cur;
            best_size = chunk_size;
         end
         cur = arena_read(cur, bfa_pkg::FLD_NEXT);
      end
      if (found == 0) return bfa_pkg::STATUS_NO_SPACE;
      if (best_size > need + bfa_pkg::CHUNK_OVERHEAD) begin
         // Split: the remainder becomes a new free chunk after this one.
         split_at = found + bfa_pkg::CHUNK_OVERHEAD + need;
         next_chunk = arena_read(found, bfa_pkg::FLD_NEXT);
         arena_write(split_at, bfa_pkg::FLD_TAG, bfa_pkg::TAG_FREE);
         arena_write(split_at, bfa_pkg::FLD_SIZE, best_size - bfa_pkg::CHUNK_OVERHEAD - need);
         arena_write(split_at, bfa_pkg::FLD_NEXT, next_chunk);
         arena_write(split_at, bfa_pkg::FLD_PREV, found);
         place_marker(split_at);
         if (next_chunk != 0) arena_write(next_chunk, bfa_pkg::FLD_PREV, split_at);
         arena_write(found, bfa_pkg::FLD_NEXT, split_at);
         arena_write(found, bfa_pkg::FLD_SIZE, need);
         place_marker(found);
         free_sum -= 32'(need + bfa_pkg::CHUNK_OVERHEAD);
         used_sum += 32'(need);
      end else begin
         free_sum -= 32'(best_size);
         used_sum += 32'(best_size);
      end
      arena_write(found, bfa_pkg::FLD_TAG, bfa_pkg::TAG_OCCUPIED);
      live_count++;
      return bfa_pkg::STATUS_OK;
   endfunction

   // Free only a chunk on the chain that is occupied; merge with next, then previous.
   function automatic bfa_pkg::status_type predict_free(bit [63:0] target);
      bit [63:0] cur, neighbor, after, size;
      bit        hit;
      cur = bfa_pkg::FIRST_CHUNK;
      hit = 1'b0;
      for (int n = 0; n < ARENA_WORDS && cur != 0; n++) begin
         if (cur == target) begin
            hit = (arena_read(cur, bfa_pkg::FLD_TAG) == bfa_pkg::TAG_OCCUPIED);
            break;
         end
         cur = arena_read(cur, bfa_pkg::FLD_NEXT);
      end
      if (!hit) return bfa_pkg::STATUS_BAD_FREE;
      size = arena_read(target, bfa_pkg::FLD_SIZE);
      arena_write(target, bfa_pkg::FLD_TAG, bfa_pkg::TAG_FREE);
      used_sum -= 32'(size);
      free_sum += 32'(size);
      live_count--;
      neighbor = arena_read(target, bfa_pkg::FLD_NEXT);
      if (neighbor != 0 && arena_read(neighbor, bfa_pkg::FLD_TAG) == bfa_pkg::TAG_FREE) begin
         after = arena_read(neighbor, bfa_pkg::FLD_NEXT);
         arena_write(target, bfa_pkg::FLD_NEXT, after);
         arena_write(target, bfa_pkg::FLD_SIZE, arena_read(target, bfa_pkg::FLD_SIZE) +
                     arena_read(neighbor, bfa_pkg::FLD_SIZE) + bfa_pkg::CHUNK_OVERHEAD);
         if (after != 0) arena_write(after, bfa_pkg::FLD_PREV, target);
         free_sum += bfa_pkg::CHUNK_OVERHEAD;
      end
      neighbor = arena_read(target, bfa_pkg::FLD_PREV);
      if (neighbor != 0 && arena_read(neighbor, bfa_pkg::FLD_TAG) == bfa_pkg::TAG_FREE) begin
         after = arena_read(target, bfa_pkg::FLD_NEXT);
         if (after != 0) arena_write(after, bfa_pkg::FLD_PREV, neighbor);
         arena_write(neighbor, bfa_pkg::FLD_NEXT, after);
         arena_write(neighbor, bfa_pkg::FLD_SIZE, arena_read(neighbor, bfa_pkg::FLD_SIZE) +
                     arena_read(target, bfa_pkg::FLD_SIZE) + bfa_pkg::CHUNK_OVERHEAD);
         free_sum += bfa_pkg::CHUNK_OVERHEAD;
      end
      return bfa_pkg::STATUS_OK;
   endfunction

   // -----------------------------------------------------------------------
   // Request side. The expected response is computed when the transfer is
   // offered; only one sender exists, so offer order equals accept order.
   // The valid is lowered only when an idle cycle follows, so it is never
   // dropped and raised again in one time step.
   // -----------------------------------------------------------------------
   task automatic send_request(bfa_pkg::func_type func, bit [15:0] bytes, bit [15:0] offset);
      alloc_response_type expected;
      bit [63:0]          found;
      found = 0;
      if (func == bfa_pkg::FUNC_ALLOC) begin
         expected.status = predict_alloc(bytes, found);
         if (expected.status == bfa_pkg::STATUS_OK) begin
            live_offsets.push_back(found[31:0]);
            alloc_ok_count++;
         end else no_space_count++;
      end else begin
         expected.status = predict_free(offset);
         if (expected.status == bfa_pkg::STATUS_OK) begin
            foreach (live_offsets[i])
               if (live_offsets[i] == offset) begin
                  live_offsets.delete(i);
                  break;
               end
            free_ok_count++;
         end else bad_free_count++;
      end
      expected.offset = found[15:0];
      expected.used   = used_sum[16:0];
      expected.free   = free_sum[16:0];
      expected.count  = live_count[11:0];

      if (idle_enable && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      pending_responses.push_back(expected);
      req_tvalid <= 1'b1;
      req_tdata  <= {offset, bytes};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
   endtask

   // Lowers the valid after the last transfer and waits for every response.
   task automatic wait_all_responses();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // -----------------------------------------------------------------------
   // Response side: random ready, plus long hold-offs counted here.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= !(idle_enable && $urandom_range(99) < 16);
      end
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      alloc_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== want.offset) begin
               $error("result_offset: expected %0d, actual %0d", want.offset,
                      rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[32:16] !== want.used) begin
               $error("used_bytes: expected %0d, actual %0d", want.used, rsp_tdata[32:16]);
               error_count++;
            end
            if (rsp_tdata[49:33] !== want.free) begin
               $error("free_bytes: expected %0d, actual %0d", want.free, rsp_tdata[49:33]);
               error_count++;
            end
            if (rsp_tdata[61:50] !== want.count) begin
               $error("alloc_count: expected %0d, actual %0d", want.count,
                      rsp_tdata[61:50]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet);
         $display("tb_best_fit_block_allocator failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // Zero request, rounding, a request too large, and further small
   // requests.
   task automatic test_alloc_edges();
      send_request(bfa_pkg::FUNC_ALLOC, 16'd0, 16'hFFFF);
      send_request(bfa_pkg::FUNC_ALLOC, 16'd1, 16'h0000);
      send_request(bfa_pkg::FUNC_ALLOC, 16'd9, 16'h5555);
      send_request(bfa_pkg::FUNC_ALLOC, 16'hFFFF, 16'hAAAA);
      send_request(bfa_pkg::FUNC_ALLOC, 16'd100, 16'd0);
      send_request(bfa_pkg::FUNC_ALLOC, 16'd48, 16'd0);
   endtask

   // Bad frees, a double free, and frees that merge on each side.
   task automatic test_free_cases();
      send_request(bfa_pkg::FUNC_FREE, 16'hAAAA, 16'd0);
      send_request(bfa_pkg::FUNC_FREE, 16'h5555, 16'hFFFF);
      send_request(bfa_pkg::FUNC_FREE, 16'd0, 16'd17);
      send_request(bfa_pkg::FUNC_FREE, 16'd0, 16'(live_offsets[1]));
      send_request(bfa_pkg::FUNC_FREE, 16'd0,
                   16'(bfa_pkg::FIRST_CHUNK + bfa_pkg::CHUNK_OVERHEAD));
      send_request(bfa_pkg::FUNC_FREE, 16'd0, 16'(live_offsets[0]));
      send_request(bfa_pkg::FUNC_FREE, 16'd0, 16'(live_offsets[0]));
      // Best fit: the small hole must be chosen over the large tail.
      send_request(bfa_pkg::FUNC_ALLOC, 16'd7, 16'd0);
      while (live_offsets.size() != 0)
         send_request(bfa_pkg::FUNC_FREE, 16'd0,
                      16'(live_offsets[live_offsets.size() - 1]));
      // Whole free arena in one chunk, then release it.
      send_request(bfa_pkg::FUNC_ALLOC, 16'(ARENA - 56), 16'd0);
      send_request(bfa_pkg::FUNC_ALLOC, 16'd0, 16'd0);
      send_request(bfa_pkg::FUNC_FREE, 16'd0, 16'(bfa_pkg::FIRST_CHUNK));
   endtask

   // Mostly well-formed alloc/free traffic with some noise.
   task automatic test_random_traffic(int items);
      int pick;
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(99);
         if (pick < 45 || live_offsets.size() == 0)
            send_request(bfa_pkg::FUNC_ALLOC, 16'($urandom_range(0, 700)), 16'($urandom));
         else if (pick < 50)
            send_request(bfa_pkg::FUNC_ALLOC, 16'($urandom), 16'($urandom));
         else if (pick < 88)
            send_request(bfa_pkg::FUNC_FREE, 16'($urandom),
                         16'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]));
         else
            send_request(bfa_pkg::FUNC_FREE, 16'($urandom), 16'($urandom));
      end
   endtask

   // The receiver stops long enough for the request side to back up.
   task automatic test_backpressure();
      idle_enable = 1'b0;
      @(posedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 10; i++)
         send_request(bfa_pkg::FUNC_ALLOC, 16'($urandom_range(0, 64)), 16'd0);
      idle_enable = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      arena_init();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_alloc_edges();
      test_free_cases();
      test_random_traffic(60);
      // The sender pauses until the block has answered everything.
      wait_all_responses();
      test_backpressure();
      idle_enable = 1'b0;
      test_random_traffic(30);
      idle_enable = 1'b1;
      test_random_traffic(60);

      wait_all_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d good and %0d failed allocations, %0d good and %0d rejected frees",
               alloc_ok_count, no_space_count, free_ok_count, bad_free_count);
      $display("with random idling, a long response hold-off and a full drain pause");
      if (error_count == 0 && pending_responses.size() == 0)
         $display("tb_best_fit_block_allocator passed");
      else
         $display("tb_best_fit_block_allocator failed");
      $finish;
   end

endmodule

`default_nettype wire
